// ----- hdl/pktb_pkg.sv -----
// Package for the per-key token bucket limiter.
// Holds parameter defaults, register indexes, outcome codes, token constants and reset values.
// No dependencies.
package pktb_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_KEY_BITS      = 32;
    localparam int DEF_TIME_BITS     = 48;
    localparam int DEF_SWEEP_EVERY   = 1024;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_REFILL_RATE    = 3'd0,
        REG_BURST_LIMIT    = 3'd1,
        REG_ENTRY_LIMIT    = 3'd2,
        REG_IDLE_LIMIT     = 3'd3,
        REG_SWEEP_INTERVAL = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OUT_PASS_EXISTING = 2'd0,
        OUT_PASS_NEW      = 2'd1,
        OUT_EMPTY         = 2'd2,
        OUT_TABLE_FULL    = 2'd3
    } outcome_t;

    localparam logic [31:0] ONE_TOKEN = 32'h0001_0000;

    localparam logic [31:0] RST_REFILL_RATE    = 32'd43;
    localparam logic [31:0] RST_BURST_LIMIT    = 32'd655360;
    localparam logic [6:0]  RST_ENTRY_LIMIT    = 7'd64;
    localparam logic [47:0] RST_IDLE_LIMIT     = 48'd300000000000;
    localparam logic [47:0] RST_SWEEP_INTERVAL = 48'd60000000000;

endpackage

// ----- hdl/pktb_mul.sv -----
// Shared 32x32 multiplier with registered product.
// Used twice per refill (upper and lower halves of elapsed time). No package use.
module pktb_mul
(
    input  logic        clk,
    input  logic [31:0] mul_a,
    input  logic [31:0] mul_b,
    output logic [63:0] mul_prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    assign mul_prod = prod_reg;

endmodule

// ----- hdl/pktb_table.sv -----
// Bucket table: key, token and last-seen memory with registered read,
// plus per-entry valid flops and a count of valid entries. No package use.
module pktb_table
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 32,
    parameter int TIME_BITS     = 48
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]   rd_addr,
    output logic                               rd_valid,
    output logic [KEY_BITS-1:0]                rd_key,
    output logic [31:0]                        rd_tokens,
    output logic [TIME_BITS-1:0]               rd_seen,
    input  logic                               wr_en,
    input  logic                               wr_new,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]   wr_addr,
    input  logic [KEY_BITS-1:0]                wr_key,
    input  logic [31:0]                        wr_tokens,
    input  logic [TIME_BITS-1:0]               wr_seen,
    input  logic                               clr_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]   clr_addr,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] count
);

    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);

    logic [KEY_BITS-1:0]  key_mem  [TABLE_ENTRIES];
    logic [31:0]          tok_mem  [TABLE_ENTRIES];
    logic [TIME_BITS-1:0] seen_mem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [CNTW-1:0]          count_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            tok_mem[wr_addr]  <= wr_tokens;
            seen_mem[wr_addr] <= wr_seen;
        end
        rd_key    <= key_mem[rd_addr];
        rd_tokens <= tok_mem[rd_addr];
        rd_seen   <= seen_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en && wr_new)
            begin
                valid_reg[wr_addr] <= 1'b1;
                count_reg          <= count_reg + CNTW'(1);
            end
            else if (clr_en)
            begin
                valid_reg[clr_addr] <= 1'b0;
                count_reg           <= count_reg - CNTW'(1);
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign count    = count_reg;

endmodule

// ----- hdl/per_key_token_bucket_limiter.sv -----
// Top level of the per-key token bucket limiter: sequencer and config registers.
// Depends on pktb_pkg, pktb_table and pktb_mul.
//
// Use: pulse start with client_key and timestamp while busy is low; the
// request transfer happens at that edge and busy rises for the whole job.
// Exactly one result per request comes back on allowed/outcome/tokens_left/
// entries_used, valid for the single cycle that done is high. The receiver
// cannot stall; it must take the result in that cycle.
// A request that hits keeps busy high through a scan of the table memory's
// single read port, then elapsed time, two passes through the shared
// multiplier, the clamped sum and the write back. A miss skips the refill.
// done rises in the same cycle that busy falls.
// Every SWEEP_EVERY-th request adds an interval check, and when the sweep
// interval has elapsed another scan that frees idle buckets. One request
// is in flight at a time.
// Configuration: cfg_valid/cfg_ready transfer with cfg_index and cfg_data,
// always ready; write only while busy is low.
// Reset clears all buckets, the request counter, the last sweep time and
// loads the register defaults; no clearing pass is needed.
module per_key_token_bucket_limiter
#(
    parameter int TABLE_ENTRIES = pktb_pkg::DEF_TABLE_ENTRIES,
    parameter int KEY_BITS      = pktb_pkg::DEF_KEY_BITS,
    parameter int TIME_BITS     = pktb_pkg::DEF_TIME_BITS,
    parameter int SWEEP_EVERY   = pktb_pkg::DEF_SWEEP_EVERY
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [KEY_BITS-1:0]                client_key,
    input  logic [TIME_BITS-1:0]               timestamp,
    output logic                               done,
    output logic                               allowed,
    output logic [1:0]                         outcome,
    output logic [31:0]                        tokens_left,
    output logic [6:0]                         entries_used,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pktb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [pktb_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    import pktb_pkg::*;

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam int RCW  = $clog2(SWEEP_EVERY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP_CHK,
        S_SWEEP,
        S_LOOK,
        S_ELAPSED,
        S_MUL_HI,
        S_MUL_LO,
        S_SUM,
        S_FINISH
    } state_t;

    state_t state_reg;

    // config registers
    logic [31:0] refill_rate_reg;
    logic [31:0] burst_limit_reg;
    logic [6:0]  entry_limit_reg;
    logic [47:0] idle_limit_reg;
    logic [47:0] sweep_interval_reg;

    logic [KEY_BITS-1:0]  key_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [RCW-1:0]       req_cnt_reg;
    logic [TIME_BITS-1:0] last_sweep_reg;

    // scan pipeline: address issued, data checked in the cycle after
    logic [AW:0]   issue_reg;
    logic          chk_vld_reg;
    logic [AW-1:0] chk_idx_reg;

    logic                 hit_reg;
    logic [AW-1:0]        hit_idx_reg;
    logic                 free_reg;
    logic [AW-1:0]        free_idx_reg;
    logic [31:0]          tok_reg;
    logic [TIME_BITS-1:0] seen_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic                 hi_sat_reg;
    logic [15:0]          hi_part_reg;
    logic [31:0]          refill_reg;

    logic        done_reg;
    logic        allowed_reg;
    logic [1:0]  outcome_reg;
    logic [31:0] tokens_reg;
    logic [6:0]  entries_reg;

    // table interface
    logic                 rd_valid;
    logic [KEY_BITS-1:0]  rd_key;
    logic [31:0]          rd_tokens;
    logic [TIME_BITS-1:0] rd_seen;
    logic                 wr_en;
    logic                 wr_new;
    logic [AW-1:0]        wr_addr;
    logic [31:0]          wr_tokens;
    logic                 clr_en;
    logic [CNTW-1:0]      count;

    logic [31:0] mul_a;
    logic [63:0] mul_prod;

    logic                 accept;
    logic                 scan_done;
    logic [RCW-1:0]       req_cnt_inc;
    logic [TIME_BITS-1:0] idle_ticks;
    logic [TIME_BITS-1:0] since_sweep;
    logic [63:0]          elapsed_ext;
    logic [49:0]          refill_sum;
    logic                 spend_ok;
    logic                 can_create;
    logic [31:0]          new_tokens;
    logic                 fin_allowed;
    outcome_t             fin_outcome;
    logic [31:0]          fin_tokens;
    logic [CNTW-1:0]      fin_count;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign scan_done = (issue_reg == (AW+1)'(TABLE_ENTRIES)) && !chk_vld_reg;
    assign req_cnt_inc = req_cnt_reg + RCW'(1);

    // saturating time differences
    assign idle_ticks  = (now_reg >= rd_seen) ? now_reg - rd_seen : '0;
    assign since_sweep = (now_reg >= last_sweep_reg) ? now_reg - last_sweep_reg : '0;
    assign elapsed_ext = 64'(elapsed_reg);

    // shared multiplier: upper elapsed half first, lower half next
    assign mul_a = (state_reg == S_MUL_HI) ? elapsed_ext[63:32] : elapsed_ext[31:0];

    assign refill_sum = 50'(tok_reg) + 50'({hi_part_reg, 16'h0000}) + 50'(mul_prod[63:16]);

    assign spend_ok   = (refill_reg >= ONE_TOKEN);
    assign can_create = free_reg && (16'(count) < 16'(entry_limit_reg));
    assign new_tokens = (burst_limit_reg >= ONE_TOKEN) ? burst_limit_reg - ONE_TOKEN : '0;

    always_comb
    begin
        fin_allowed = 1'b0;
        fin_outcome = OUT_TABLE_FULL;
        fin_tokens  = '0;
        fin_count   = count;
        wr_en       = 1'b0;
        wr_new      = 1'b0;
        wr_addr     = hit_idx_reg;
        wr_tokens   = '0;
        if (hit_reg)
        begin
            fin_tokens  = spend_ok ? refill_reg - ONE_TOKEN : refill_reg;
            fin_allowed = spend_ok;
            fin_outcome = spend_ok ? OUT_PASS_EXISTING : OUT_EMPTY;
            wr_en       = (state_reg == S_FINISH);
            wr_tokens   = fin_tokens;
        end
        else if (can_create)
        begin
            fin_tokens  = new_tokens;
            fin_allowed = 1'b1;
            fin_outcome = OUT_PASS_NEW;
            fin_count   = count + CNTW'(1);
            wr_en       = (state_reg == S_FINISH);
            wr_new      = 1'b1;
            wr_addr     = free_idx_reg;
            wr_tokens   = new_tokens;
        end
    end

    // sweep frees a bucket idle strictly longer than the limit
    assign clr_en = (state_reg == S_SWEEP) && chk_vld_reg && rd_valid &&
                    (64'(idle_ticks) > 64'(idle_limit_reg));

    pktb_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .TIME_BITS     (TIME_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (issue_reg[AW-1:0]),
        .rd_valid  (rd_valid),
        .rd_key    (rd_key),
        .rd_tokens (rd_tokens),
        .rd_seen   (rd_seen),
        .wr_en     (wr_en),
        .wr_new    (wr_new),
        .wr_addr   (wr_addr),
        .wr_key    (key_reg),
        .wr_tokens (wr_tokens),
        .wr_seen   (now_reg),
        .clr_en    (clr_en),
        .clr_addr  (chk_idx_reg),
        .count     (count)
    );

    pktb_mul u_mul (
        .clk      (clk),
        .mul_a    (mul_a),
        .mul_b    (refill_rate_reg),
        .mul_prod (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            refill_rate_reg    <= RST_REFILL_RATE;
            burst_limit_reg    <= RST_BURST_LIMIT;
            entry_limit_reg    <= RST_ENTRY_LIMIT;
            idle_limit_reg     <= RST_IDLE_LIMIT;
            sweep_interval_reg <= RST_SWEEP_INTERVAL;
            req_cnt_reg        <= '0;
            last_sweep_reg     <= '0;
            issue_reg          <= '0;
            chk_vld_reg        <= 1'b0;
            hit_reg            <= 1'b0;
            free_reg           <= 1'b0;
            done_reg           <= 1'b0;
        end
        else
        begin
            // strobe for one cycle after the finishing state
            done_reg <= (state_reg == S_FINISH);

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_REFILL_RATE:    refill_rate_reg    <= cfg_data[31:0];
                    REG_BURST_LIMIT:    burst_limit_reg    <= cfg_data[31:0];
                    REG_ENTRY_LIMIT:    entry_limit_reg    <= cfg_data[6:0];
                    REG_IDLE_LIMIT:     idle_limit_reg     <= cfg_data[47:0];
                    REG_SWEEP_INTERVAL: sweep_interval_reg <= cfg_data[47:0];
                    default:            ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg   <= client_key;
                        now_reg   <= timestamp;
                        issue_reg <= '0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        if (32'(req_cnt_inc) >= 32'(SWEEP_EVERY))
                        begin
                            req_cnt_reg <= '0;
                            state_reg   <= S_SWEEP_CHK;
                        end
                        else
                        begin
                            req_cnt_reg <= req_cnt_inc;
                            state_reg   <= S_LOOK;
                        end
                    end
                end
                S_SWEEP_CHK:
                begin
                    if (64'(since_sweep) >= 64'(sweep_interval_reg))
                    begin
                        last_sweep_reg <= now_reg;
                        state_reg      <= S_SWEEP;
                    end
                    else
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_SWEEP, S_LOOK:
                begin
                    if (issue_reg != (AW+1)'(TABLE_ENTRIES))
                    begin
                        issue_reg   <= issue_reg + (AW+1)'(1);
                        chk_vld_reg <= 1'b1;
                        chk_idx_reg <= issue_reg[AW-1:0];
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                    end
                    if (state_reg == S_LOOK && chk_vld_reg)
                    begin
                        if (rd_valid)
                        begin
                            if (!hit_reg && rd_key == key_reg)
                            begin
                                hit_reg     <= 1'b1;
                                hit_idx_reg <= chk_idx_reg;
                                tok_reg     <= rd_tokens;
                                seen_reg    <= rd_seen;
                            end
                        end
                        else if (!free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= chk_idx_reg;
                        end
                    end
                    if (scan_done)
                    begin
                        issue_reg <= '0;
                        if (state_reg == S_SWEEP)
                            state_reg <= S_LOOK;
                        else
                            state_reg <= hit_reg ? S_ELAPSED : S_FINISH;
                    end
                end
                S_ELAPSED:
                begin
                    elapsed_reg <= (now_reg >= seen_reg) ? now_reg - seen_reg : '0;
                    state_reg   <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    state_reg <= S_MUL_LO;
                end
                S_MUL_LO:
                begin
                    // upper product at or above 2^16 (65536 tokens in Q16.16) saturates
                    hi_sat_reg  <= (mul_prod >= 64'h1_0000);
                    hi_part_reg <= mul_prod[15:0];
                    state_reg   <= S_SUM;
                end
                S_SUM:
                begin
                    if (hi_sat_reg || refill_sum > 50'(burst_limit_reg))
                        refill_reg <= burst_limit_reg;
                    else
                        refill_reg <= refill_sum[31:0];
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    allowed_reg <= fin_allowed;
                    outcome_reg <= fin_outcome;
                    tokens_reg  <= fin_tokens;
                    entries_reg <= 7'(fin_count);
                    state_reg   <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign allowed      = allowed_reg;
    assign outcome      = outcome_reg;
    assign tokens_left  = tokens_reg;
    assign entries_used = entries_reg;

    // result is only shown once the job has finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request transfer did not start a job");

    // table-full results report no tokens
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && outcome == OUT_TABLE_FULL) |-> (!allowed && tokens_left == '0))
        else $error("table full result carries tokens");

    // allowed agrees with the outcome code
    a_allowed_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (allowed == (outcome == OUT_PASS_EXISTING || outcome == OUT_PASS_NEW)))
        else $error("allowed disagrees with outcome");

    // the table write of a finished job never coincides with a sweep free
    a_wr_clr: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && clr_en))
        else $error("table write and clear in the same cycle");

endmodule
